// File: hw/rtl/rnv12_pkg.sv
package rnv12_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;
    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int PIX_W     = 8;
    localparam int LIDX_W    = 24;
    localparam int CIDX_W    = 23;
    localparam int CFG_IDX_W = 1;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int SUM_W     = 18;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);
    localparam logic [DIM_W-1:0] DIM_MAX_V  = DIM_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [LIDX_W-1:0] luma_index;
        logic              chroma_valid;
        logic [CIDX_W-1:0] chroma_index;
        logic              frame_end;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [LIDX_W-1:0] luma_index;
        logic              chroma_valid;
        logic [PIX_W-1:0]  cb;
        logic [PIX_W-1:0]  cr;
        logic [CIDX_W-1:0] chroma_index;
        logic              frame_end;
    } t_result;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_MAX_V) begin
            res = DIM_MAX_V;
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_u9(input logic [PIX_W:0] v);
        return v[PIX_W] ? {PIX_W{1'b1}} : v[PIX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/rnv12_pix_if.sv
interface rnv12_pix_if;
    import rnv12_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

// File: hw/rtl/rnv12_res_if.sv
interface rnv12_res_if;
    import rnv12_pkg::*;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  luma;
    logic [LIDX_W-1:0] luma_index;
    logic              chroma_valid;
    logic [PIX_W-1:0]  cb;
    logic [PIX_W-1:0]  cr;
    logic [CIDX_W-1:0] chroma_index;
    logic              frame_end;

    modport source (output valid, luma, luma_index, chroma_valid, cb, cr, chroma_index,
                    frame_end, input ready);
    modport sink (input valid, luma, luma_index, chroma_valid, cb, cr, chroma_index,
                  frame_end, output ready);
endinterface

// File: hw/rtl/rnv12_front.sv
module rnv12_front
    import rnv12_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    rnv12_pix_if.sink            i_pix,
    input  logic                 i_full,
    output logic                 o_push,
    output t_item                o_item
);

    logic [DIM_W-1:0]  r_width, n_width;
    logic [DIM_W-1:0]  r_height, n_height;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [LIDX_W-1:0] r_luma_idx, n_luma_idx;
    logic [CIDX_W-1:0] r_cbase, n_cbase;
    logic              last_col;
    logic              last_row;
    logic              cvalid;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    assign last_col = {1'b0, r_col} >= (r_width - DIM_W'(1));
    assign last_row = {1'b0, r_row} >= (r_height - DIM_W'(1));
    assign cvalid   = !r_row[0] && !r_col[0];

    always_comb begin
        o_item.red          = i_pix.red;
        o_item.green        = i_pix.green;
        o_item.blue         = i_pix.blue;
        o_item.luma_index   = r_luma_idx;
        o_item.chroma_valid = cvalid;
        o_item.chroma_index = cvalid ? (r_cbase + CIDX_W'(r_col)) : '0;
        o_item.frame_end    = last_col && last_row;
    end

    always_comb begin
        n_width    = r_width;
        n_height   = r_height;
        n_col      = r_col;
        n_row      = r_row;
        n_luma_idx = r_luma_idx;
        n_cbase    = r_cbase;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:  n_width  = eff_dim(i_cfg_data);
                REG_FRAME_HEIGHT: n_height = eff_dim(i_cfg_data);
                default: ;
            endcase
            n_col      = '0;
            n_row      = '0;
            n_luma_idx = '0;
            n_cbase    = '0;
        end else if (o_push) begin
            n_luma_idx = r_luma_idx + LIDX_W'(1);
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row      = '0;
                    n_luma_idx = '0;
                    n_cbase    = '0;
                end else begin
                    n_row = r_row + CNT_W'(1);
                    if (r_row[0]) begin
                        n_cbase = r_cbase + CIDX_W'(r_width);
                    end
                end
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RST;
            r_height   <= HEIGHT_RST;
            r_col      <= '0;
            r_row      <= '0;
            r_luma_idx <= '0;
            r_cbase    <= '0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_col      <= n_col;
            r_row      <= n_row;
            r_luma_idx <= n_luma_idx;
            r_cbase    <= n_cbase;
        end
    end

`ifndef SYNTH
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_width)
        else $error("column beyond frame width");
    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < r_height)
        else $error("row beyond frame height");
    a_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.frame_end && !i_cfg_we) |=> (r_luma_idx == '0 && r_cbase == '0))
        else $error("frame wrap did not clear indices");
`endif

endmodule

// File: hw/rtl/rnv12_queue.sv
module rnv12_queue
    import rnv12_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

// File: hw/rtl/rnv12_back.sv
module rnv12_back
    import rnv12_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    rnv12_res_if.source o_res
);

    typedef struct packed {
        logic [LIDX_W-1:0] luma_index;
        logic              chroma_valid;
        logic [CIDX_W-1:0] chroma_index;
        logic              frame_end;
        logic [PIX_W:0]    y9;
        logic [PIX_W:0]    u9;
        logic [PIX_W:0]    v9;
    } t_stage;

    logic signed [SUM_W-1:0] r_s, g_s, b_s;
    logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
    logic signed [SUM_W-1:0] u_bias, v_bias;
    logic                    adv;
    logic                    load_s1;
    t_stage                  s1_next;
    t_stage                  r_s1;
    logic                    r_s1_valid;
    t_result                 r_out;
    logic                    r_out_valid;

    assign adv     = !r_out_valid || o_res.ready;
    assign load_s1 = adv || !r_s1_valid;
    assign o_pop   = i_valid && load_s1;

    assign r_s = $signed({{(SUM_W-PIX_W){1'b0}}, i_item.red});
    assign g_s = $signed({{(SUM_W-PIX_W){1'b0}}, i_item.green});
    assign b_s = $signed({{(SUM_W-PIX_W){1'b0}}, i_item.blue});

    assign y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
    assign u_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
    assign v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;
    assign u_bias = u_sum + 18'sd32768;
    assign v_bias = v_sum + 18'sd32768;

    always_comb begin
        s1_next.luma_index   = i_item.luma_index;
        s1_next.chroma_valid = i_item.chroma_valid;
        s1_next.chroma_index = i_item.chroma_index;
        s1_next.frame_end    = i_item.frame_end;
        s1_next.y9           = y_sum[16:8] + (PIX_W+1)'(16);
        s1_next.u9           = u_bias[16:8];
        s1_next.v9           = v_bias[16:8];
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1 <= s1_next;
        end
        if (adv && r_s1_valid) begin
            r_out.luma         <= clamp_u9(r_s1.y9);
            r_out.luma_index   <= r_s1.luma_index;
            r_out.chroma_valid <= r_s1.chroma_valid;
            r_out.cb           <= r_s1.chroma_valid ? clamp_u9(r_s1.u9) : '0;
            r_out.cr           <= r_s1.chroma_valid ? clamp_u9(r_s1.v9) : '0;
            r_out.chroma_index <= r_s1.chroma_index;
            r_out.frame_end    <= r_s1.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.luma         = r_out.luma;
    assign o_res.luma_index   = r_out.luma_index;
    assign o_res.chroma_valid = r_out.chroma_valid;
    assign o_res.cb           = r_out.cb;
    assign o_res.cr           = r_out.cr;
    assign o_res.chroma_index = r_out.chroma_index;
    assign o_res.frame_end    = r_out.frame_end;

`ifndef SYNTH
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stage 1 item lost while stalled");
    a_no_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.chroma_valid) |->
            (r_out.cb == '0 && r_out.cr == '0 && r_out.chroma_index == '0))
        else $error("chroma fields set on pixel without chroma");
    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_s1_valid || adv))
        else $error("pop while stage 1 blocked");
`endif

endmodule

// File: hw/rtl/rgb_to_nv12_converter_core.sv
// Channel   Dir  Handshake            Payload
// i_pix     in   valid/ready          red, green, blue
// o_res     out  valid/ready          luma, luma_index, chroma_valid, cb, cr,
//                                     chroma_index, frame_end
// i_cfg_*   in   write enable only    index 0 frame_width, 1 frame_height
//
// One pixel per cycle sustained while the queue is not full and the output is not stalled;
// an accepted pixel is written to the queue, then the product stage, then the output register.
// Position counters and indices are updated incrementally in the front, no multiplier.
// Synchronous active-low reset clears counters and valids; sizes go to 1920 x 1080.
// A full two-entry queue drops i_pix.ready; a stalled output holds the back pipeline.
// A register write restarts the frame at row 0, column 0.
module rgb_to_nv12_converter_core
    import rnv12_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    rnv12_pix_if.sink            i_pix,
    rnv12_res_if.source          o_res
);

    logic  push;
    logic  pop;
    logic  full;
    logic  q_valid;
    t_item front_item;
    t_item q_item;

    rnv12_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_full     (full),
        .o_push     (push),
        .o_item     (front_item)
    );

    rnv12_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rnv12_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
